### rtl/gsrd_pkg.sv
// Shared constants, codes and types of the grouped sparse row dot block.
`default_nettype none
package gsrd_pkg;

    localparam int LANES      = 4;
    localparam int LANE_W     = $clog2(LANES);
    localparam int X_DEPTH    = 1024;
    localparam int XA_W       = $clog2(X_DEPTH);
    localparam int BANK_DEPTH = X_DEPTH / LANES;
    localparam int BA_W       = $clog2(BANK_DEPTH);

    localparam int TYPE_W = 2;
    localparam int IDX_W  = 10;
    localparam int VAL_W  = 16;
    localparam int COL_W  = ((IDX_W > XA_W) ? IDX_W : XA_W) + 1;
    localparam int PROD_W = 2 * VAL_W;
    localparam int GRP_W  = PROD_W + LANE_W;
    localparam int ACC_W  = 48;
    localparam int SUM_W  = ACC_W + 1;
    localparam int ROW_W  = 16;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [TYPE_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_GROUP = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_GROUP,
        OP_EMPTY
    } t_op;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        t_op                             op;
        logic [LANES-1:0]                bank_we;
        logic [BA_W-1:0]                 wr_addr;
        logic [VAL_W-1:0]                wr_data;
        logic [LANES-1:0][BA_W-1:0]      rd_addr;
        logic [LANE_W-1:0]               rot;
        logic [LANES-1:0]                lane_ok;
        logic [LANES-1:0][VAL_W-1:0]     lane_val;
        logic                            last;
    } t_cmd;

endpackage
`default_nettype wire

### rtl/gsrd_if.sv
// Request and result channel interfaces of the grouped sparse row dot block.
`default_nettype none
interface gsrd_req_if;
    logic                                   valid;
    logic                                   ready;
    logic [gsrd_pkg::TYPE_W-1:0]            req_type;
    logic [gsrd_pkg::IDX_W-1:0]             x_index;
    logic signed [gsrd_pkg::VAL_W-1:0]      x_value;
    logic [gsrd_pkg::IDX_W-1:0]             window_start;
    logic signed [gsrd_pkg::VAL_W-1:0]      lane_value_0;
    logic signed [gsrd_pkg::VAL_W-1:0]      lane_value_1;
    logic signed [gsrd_pkg::VAL_W-1:0]      lane_value_2;
    logic signed [gsrd_pkg::VAL_W-1:0]      lane_value_3;
    logic                                   row_last;

    modport source (
        output valid, req_type, x_index, x_value, window_start,
               lane_value_0, lane_value_1, lane_value_2, lane_value_3, row_last,
        input  ready
    );
    modport sink (
        input  valid, req_type, x_index, x_value, window_start,
               lane_value_0, lane_value_1, lane_value_2, lane_value_3, row_last,
        output ready
    );
endinterface

interface gsrd_res_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [gsrd_pkg::ACC_W-1:0]      row_sum;
    logic [gsrd_pkg::ROW_W-1:0]             row_number;

    modport source (output valid, row_sum, row_number, input ready);
    modport sink (input valid, row_sum, row_number, output ready);
endinterface
`default_nettype wire

### rtl/grouped_sparse_row_dot.sv
// The item that ends a row passes the command queue, stage 1 with the bank reads, stage 2,
// stage 3 and the output register. Throughput: one item per cycle unless the result channel
// stalls; the x store is split into one bank per lane, so a window reads all lanes through one
// read port per bank in a single cycle. Reset: synchronous, active low; afterwards a clearing
// sweep zeroes the x store, one bank row after another, during which no request is taken.
`default_nettype none
module grouped_sparse_row_dot (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    gsrd_req_if.sink     i_req,
    gsrd_res_if.source   o_res
);
    logic            push;
    gsrd_pkg::t_cmd  push_cmd;
    logic            q_full;
    logic            q_valid;
    gsrd_pkg::t_cmd  q_cmd;
    logic            pop;
    logic            clear_done;

    gsrd_front u_front (
        .i_clear_done (clear_done),
        .i_q_full     (q_full),
        .i_req        (i_req),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    gsrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    gsrd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_cmd        (q_cmd),
        .o_pop        (pop),
        .o_clear_done (clear_done),
        .o_res        (o_res)
    );
endmodule
`default_nettype wire

### rtl/gsrd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module gsrd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

### rtl/gsrd_front.sv
// Front end: accepts requests, drops the ones that do nothing, and works out bank addresses.
`default_nettype none
module gsrd_front (
    input  wire logic         i_clear_done,
    input  wire logic         i_q_full,
    gsrd_req_if.sink          i_req,
    output logic              o_push,
    output gsrd_pkg::t_cmd    o_cmd
);
    logic keep;

    assign i_req.ready = !i_q_full && i_clear_done;

    always_comb begin
        logic [gsrd_pkg::COL_W-1:0]  start;
        logic [gsrd_pkg::COL_W-1:0]  idx;
        logic [gsrd_pkg::COL_W-1:0]  col;
        logic [gsrd_pkg::LANE_W-1:0] k;

        start = gsrd_pkg::COL_W'(i_req.window_start);
        idx   = gsrd_pkg::COL_W'(i_req.x_index);

        o_cmd          = '0;
        o_cmd.wr_data  = i_req.x_value;
        o_cmd.bank_we  = gsrd_pkg::LANES'(1) << idx[gsrd_pkg::LANE_W-1:0];
        o_cmd.wr_addr  = idx[gsrd_pkg::XA_W-1:gsrd_pkg::LANE_W];
        o_cmd.rot      = start[gsrd_pkg::LANE_W-1:0];
        o_cmd.last     = i_req.row_last;
        o_cmd.lane_val[0] = i_req.lane_value_0;
        o_cmd.lane_val[1] = i_req.lane_value_1;
        o_cmd.lane_val[2] = i_req.lane_value_2;
        o_cmd.lane_val[3] = i_req.lane_value_3;

        // Each bank holds the columns with its own low address bits, so every
        // window touches each bank exactly once.
        for (int b = 0; b < gsrd_pkg::LANES; b++) begin
            k   = gsrd_pkg::LANE_W'(b) - start[gsrd_pkg::LANE_W-1:0];
            col = start + gsrd_pkg::COL_W'(k);
            o_cmd.rd_addr[b] = col[gsrd_pkg::XA_W-1:gsrd_pkg::LANE_W];
            o_cmd.lane_ok[b] = (start + gsrd_pkg::COL_W'(b))
                               < gsrd_pkg::COL_W'(gsrd_pkg::X_DEPTH);
        end

        unique case (i_req.req_type)
            gsrd_pkg::REQ_LOAD: begin
                o_cmd.op = gsrd_pkg::OP_LOAD;
                keep     = idx < gsrd_pkg::COL_W'(gsrd_pkg::X_DEPTH);
            end
            gsrd_pkg::REQ_GROUP: begin
                o_cmd.op = gsrd_pkg::OP_GROUP;
                keep     = 1'b1;
            end
            gsrd_pkg::REQ_EMPTY: begin
                o_cmd.op = gsrd_pkg::OP_EMPTY;
                keep     = 1'b1;
            end
            default: begin
                o_cmd.op = gsrd_pkg::OP_LOAD;
                keep     = 1'b0;
            end
        endcase
    end

    assign o_push = i_req.valid && i_req.ready && keep;
endmodule
`default_nettype wire

### rtl/gsrd_queue.sv
// Short command queue between the front end and the back end.
`default_nettype none
module gsrd_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire gsrd_pkg::t_cmd  i_cmd,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output gsrd_pkg::t_cmd       o_cmd
);
    gsrd_pkg::t_cmd                r_mem [gsrd_pkg::Q_DEPTH];
    logic [gsrd_pkg::Q_AW-1:0]     r_wr;
    logic [gsrd_pkg::Q_AW-1:0]     r_rd;
    logic [gsrd_pkg::Q_AW:0]       r_cnt;
    logic [gsrd_pkg::Q_AW:0]       n_cnt;
    logic                          do_pop;

    assign o_full  = r_cnt == (gsrd_pkg::Q_AW + 1)'(gsrd_pkg::Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && do_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end
endmodule
`default_nettype wire

### rtl/gsrd_back.sv
// Back end: banked x store, lane multipliers, group adder and saturating row accumulator.
`default_nettype none
module gsrd_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    input  wire gsrd_pkg::t_cmd  i_cmd,
    output logic                 o_pop,
    output logic                 o_clear_done,
    gsrd_res_if.source           o_res
);
    // Clearing sweep: all banks are zeroed in parallel, one row per cycle.
    logic                        r_clr_busy;
    logic [gsrd_pkg::BA_W-1:0]   r_clr_cnt;

    logic adv;

    logic [gsrd_pkg::VAL_W-1:0]  rdata [gsrd_pkg::LANES];

    logic                                        r_s1_valid;
    gsrd_pkg::t_op                               r_s1_op;
    logic                                        r_s1_last;
    logic [gsrd_pkg::LANE_W-1:0]                 r_s1_rot;
    logic [gsrd_pkg::LANES-1:0]                  r_s1_ok;
    logic [gsrd_pkg::LANES-1:0][gsrd_pkg::VAL_W-1:0] r_s1_val;

    logic signed [gsrd_pkg::PROD_W-1:0]          prod [gsrd_pkg::LANES];

    logic                                        r_s2_valid;
    gsrd_pkg::t_op                               r_s2_op;
    logic                                        r_s2_last;
    logic signed [gsrd_pkg::PROD_W-1:0]          r_s2_prod [gsrd_pkg::LANES];

    logic signed [gsrd_pkg::GRP_W-1:0]           grp;

    logic                                        r_s3_valid;
    gsrd_pkg::t_op                               r_s3_op;
    logic                                        r_s3_last;
    logic signed [gsrd_pkg::GRP_W-1:0]           r_s3_grp;

    logic signed [gsrd_pkg::ACC_W-1:0]           r_acc;
    logic signed [gsrd_pkg::ACC_W-1:0]           n_acc;
    logic [gsrd_pkg::ROW_W-1:0]                  r_row;
    logic [gsrd_pkg::ROW_W-1:0]                  n_row;
    logic                                        r_out_valid;
    logic                                        n_out_valid;
    logic signed [gsrd_pkg::ACC_W-1:0]           r_out_sum;
    logic signed [gsrd_pkg::ACC_W-1:0]           n_out_sum;
    logic [gsrd_pkg::ROW_W-1:0]                  r_out_row;
    logic [gsrd_pkg::ROW_W-1:0]                  n_out_row;

    // The whole pipeline moves only when the output register can take a result.
    assign adv          = !r_out_valid || o_res.ready;
    assign o_clear_done = !r_clr_busy;
    assign o_pop        = adv && i_q_valid && !r_clr_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == gsrd_pkg::BA_W'(gsrd_pkg::BANK_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    for (genvar b = 0; b < gsrd_pkg::LANES; b++) begin : g_bank
        logic                      we;
        logic [gsrd_pkg::BA_W-1:0] waddr;
        logic [gsrd_pkg::VAL_W-1:0] wdata;
        logic                      re;

        assign we    = r_clr_busy ||
                       (o_pop && i_cmd.op == gsrd_pkg::OP_LOAD && i_cmd.bank_we[b]);
        assign waddr = r_clr_busy ? r_clr_cnt : i_cmd.wr_addr;
        assign wdata = r_clr_busy ? '0 : i_cmd.wr_data;
        assign re    = o_pop && i_cmd.op == gsrd_pkg::OP_GROUP;

        gsrd_ram #(
            .WIDTH (gsrd_pkg::VAL_W),
            .DEPTH (gsrd_pkg::BANK_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (waddr),
            .i_wdata (wdata),
            .i_re    (re),
            .i_raddr (i_cmd.rd_addr[b]),
            .o_rdata (rdata[b])
        );
    end

    // Lane k reads the bank that holds column window_start + k.
    always_comb begin
        logic [gsrd_pkg::LANE_W-1:0]     sel;
        logic signed [gsrd_pkg::VAL_W-1:0] x;
        logic signed [gsrd_pkg::VAL_W-1:0] a;

        for (int k = 0; k < gsrd_pkg::LANES; k++) begin
            sel     = r_s1_rot + gsrd_pkg::LANE_W'(k);
            x       = r_s1_ok[k] ? $signed(rdata[sel]) : '0;
            a       = $signed(r_s1_val[k]);
            prod[k] = a * x;
        end
    end

    always_comb begin
        grp = '0;
        for (int k = 0; k < gsrd_pkg::LANES; k++) begin
            grp = grp + gsrd_pkg::GRP_W'(r_s2_prod[k]);
        end
    end

    always_comb begin
        logic signed [gsrd_pkg::SUM_W-1:0] sum;
        logic signed [gsrd_pkg::ACC_W-1:0] sat;

        sum = gsrd_pkg::SUM_W'(r_acc) + gsrd_pkg::SUM_W'(r_s3_grp);
        if (sum[gsrd_pkg::SUM_W-1] != sum[gsrd_pkg::ACC_W-1]) begin
            sat = sum[gsrd_pkg::SUM_W-1] ? {1'b1, {(gsrd_pkg::ACC_W-1){1'b0}}}
                                         : {1'b0, {(gsrd_pkg::ACC_W-1){1'b1}}};
        end else begin
            sat = sum[gsrd_pkg::ACC_W-1:0];
        end

        n_acc       = r_acc;
        n_row       = r_row;
        n_out_valid = 1'b0;
        n_out_sum   = sat;
        n_out_row   = r_row;
        if (r_s3_valid) begin
            case (r_s3_op)
                gsrd_pkg::OP_GROUP: begin
                    if (r_s3_last) begin
                        n_acc       = '0;
                        n_row       = r_row + 1'b1;
                        n_out_valid = 1'b1;
                    end else begin
                        n_acc = sat;
                    end
                end
                gsrd_pkg::OP_EMPTY: begin
                    n_row       = r_row + 1'b1;
                    n_out_valid = 1'b1;
                    n_out_sum   = '0;
                end
                default: begin
                    n_acc = r_acc;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_acc       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= o_pop && i_cmd.op != gsrd_pkg::OP_LOAD;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_acc       <= n_acc;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_op   <= i_cmd.op;
            r_s1_last <= i_cmd.last;
            r_s1_rot  <= i_cmd.rot;
            r_s1_ok   <= i_cmd.lane_ok;
            r_s1_val  <= i_cmd.lane_val;
            r_s2_op   <= r_s1_op;
            r_s2_last <= r_s1_last;
            for (int k = 0; k < gsrd_pkg::LANES; k++) begin
                r_s2_prod[k] <= prod[k];
            end
            r_s3_op   <= r_s2_op;
            r_s3_last <= r_s2_last;
            r_s3_grp  <= grp;
            if (n_out_valid) begin
                r_out_sum <= n_out_sum;
                r_out_row <= n_out_row;
            end
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.row_sum    = r_out_sum;
    assign o_res.row_number = r_out_row;
endmodule
`default_nettype wire
